/* rtl/csb_pkg.sv */
`timescale 1ns / 1ps

package csb_pkg;

	localparam int CMD_W     = 2;
	localparam int KEY_W     = 64;
	localparam int INIT_W    = 15;
	localparam int HANDLE_W  = 4;
	localparam int TASKID_W  = 8;
	localparam int STATUS_W  = 3;
	localparam int SLOTOUT_W = 4;
	localparam int CNT_W     = 16;

	localparam logic signed [CNT_W-1:0] COUNT_MAX = 16'sd32767;

	typedef enum logic [CMD_W-1:0] {
		CMD_OPEN   = 2'd0,
		CMD_WAIT   = 2'd1,
		CMD_POST   = 2'd2,
		CMD_UNLINK = 2'd3
	} cmd_e;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK         = 3'd0,
		ST_BLOCKED    = 3'd1,
		ST_FOUND      = 3'd2,
		ST_TABLE_FULL = 3'd3,
		ST_QUEUE_FULL = 3'd4,
		ST_BAD_HANDLE = 3'd5,
		ST_NOT_FOUND  = 3'd6,
		ST_SATURATED  = 3'd7
	} status_e;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DISPATCH,
		S_META,
		S_WAKE,
		S_SCAN,
		S_EMIT
	} state_e;

	// controller -> datapath
	typedef struct packed {
		logic capture;
		logic scan_start;
		logic scan;
		logic scan_fin;
		logic upd;
		logic wake_fin;
		logic res_bad;
		logic emit;
	} ctrl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_scan;
		logic handle_ok;
		logic need_wake;
		logic scan_done;
		logic out_free;
	} ctrl_sts_t;

endpackage

/* rtl/csb_req_if.sv */
`timescale 1ns / 1ps

interface csb_req_if;
	logic                          valid;
	logic                          ready;
	logic [csb_pkg::CMD_W-1:0]     command;
	logic [csb_pkg::KEY_W-1:0]     name_key;
	logic [csb_pkg::INIT_W-1:0]    init_value;
	logic [csb_pkg::HANDLE_W-1:0]  handle;
	logic [csb_pkg::TASKID_W-1:0]  task_id;

	modport source (
		output valid, command, name_key, init_value, handle, task_id,
		input  ready
	);
	modport sink (
		input  valid, command, name_key, init_value, handle, task_id,
		output ready
	);
endinterface

/* rtl/csb_rsp_if.sv */
`timescale 1ns / 1ps

interface csb_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [csb_pkg::STATUS_W-1:0]  status;
	logic [csb_pkg::SLOTOUT_W-1:0] slot_out;
	logic                          wake_valid;
	logic [csb_pkg::TASKID_W-1:0]  woken_task;

	modport source (
		output valid, status, slot_out, wake_valid, woken_task,
		input  ready
	);
	modport sink (
		input  valid, status, slot_out, wake_valid, woken_task,
		output ready
	);
endinterface

/* rtl/counting_semaphore_bank_core.sv */
`timescale 1ns / 1ps

// channel  dir  modport  beat
// req      in   sink     command, name_key, init_value, handle, task_id
// rsp      out  source   status, slot_out, wake_valid, woken_task
//
// One request at a time. Wait and post read the slot metadata, then update it; a post
// that wakes a task also reads the waiter. A bad handle goes straight to emit.
// Open and unlink run the key scan over all NUM_SEMS slots at one slot a cycle.
// A finished beat sits in the output register; the next request is taken
// while it waits. A stalled rsp holds the block in its emit step.
// arst_n clears slot used bits and control; other storage is written before use.

module counting_semaphore_bank_core #(
	parameter int NUM_SEMS    = 16,
	parameter int QUEUE_DEPTH = 16,
	parameter int TASK_BITS   = 8
) (
	input logic       clk,
	input logic       arst_n,
	csb_req_if.sink   req,
	csb_rsp_if.source rsp
);

	csb_pkg::ctrl_cmd_t cmd;
	csb_pkg::ctrl_sts_t sts;
	logic               in_ready;

	csb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	csb_dp #(
		.NUM_SEMS    (NUM_SEMS),
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.TASK_BITS   (TASK_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_command    (req.command),
		.in_name_key   (req.name_key),
		.in_init_value (req.init_value),
		.in_handle     (req.handle),
		.in_task_id    (req.task_id),
		.cmd           (cmd),
		.sts           (sts),
		.out_valid     (rsp.valid),
		.out_ready     (rsp.ready),
		.out_status    (rsp.status),
		.out_slot      (rsp.slot_out),
		.out_wake      (rsp.wake_valid),
		.out_woken     (rsp.woken_task)
	);

	assign req.ready = in_ready;

endmodule

/* rtl/csb_ctrl.sv */
`timescale 1ns / 1ps

module csb_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  csb_pkg::ctrl_sts_t sts,
	output csb_pkg::ctrl_cmd_t cmd
);

	csb_pkg::state_e state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= csb_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			csb_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = csb_pkg::S_DISPATCH;
				end
			end
			csb_pkg::S_DISPATCH: begin
				if (sts.is_scan) begin
					cmd.scan_start = 1'b1;
					state_d        = csb_pkg::S_SCAN;
				end else if (!sts.handle_ok) begin
					cmd.res_bad = 1'b1;
					state_d     = csb_pkg::S_EMIT;
				end else begin
					// slot metadata read is in flight this cycle
					state_d = csb_pkg::S_META;
				end
			end
			csb_pkg::S_META: begin
				cmd.upd = 1'b1;
				state_d = sts.need_wake ? csb_pkg::S_WAKE : csb_pkg::S_EMIT;
			end
			csb_pkg::S_WAKE: begin
				cmd.wake_fin = 1'b1;
				state_d      = csb_pkg::S_EMIT;
			end
			csb_pkg::S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_done) begin
					cmd.scan_fin = 1'b1;
					state_d      = csb_pkg::S_EMIT;
				end
			end
			csb_pkg::S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = csb_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = csb_pkg::S_IDLE;
			end
		endcase
	end

endmodule

/* rtl/csb_dp.sv */
`timescale 1ns / 1ps

module csb_dp #(
	parameter int NUM_SEMS    = 16,
	parameter int QUEUE_DEPTH = 16,
	parameter int TASK_BITS   = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [csb_pkg::CMD_W-1:0]          in_command,
	input  logic [csb_pkg::KEY_W-1:0]          in_name_key,
	input  logic [csb_pkg::INIT_W-1:0]         in_init_value,
	input  logic [csb_pkg::HANDLE_W-1:0]       in_handle,
	input  logic [csb_pkg::TASKID_W-1:0]       in_task_id,
	input  csb_pkg::ctrl_cmd_t                 cmd,
	output csb_pkg::ctrl_sts_t                 sts,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [csb_pkg::STATUS_W-1:0]       out_status,
	output logic [csb_pkg::SLOTOUT_W-1:0]      out_slot,
	output logic                               out_wake,
	output logic [csb_pkg::TASKID_W-1:0]       out_woken
);

	localparam int KEY_W     = csb_pkg::KEY_W;
	localparam int INIT_W    = csb_pkg::INIT_W;
	localparam int HANDLE_W  = csb_pkg::HANDLE_W;
	localparam int TASKID_W  = csb_pkg::TASKID_W;
	localparam int SLOTOUT_W = csb_pkg::SLOTOUT_W;
	localparam int CNT_W     = csb_pkg::CNT_W;
	localparam int SLOT_W    = $clog2(NUM_SEMS);
	localparam int IDX_W     = $clog2(NUM_SEMS + 1);
	localparam int Q_W       = $clog2(QUEUE_DEPTH);
	localparam int WDEPTH    = NUM_SEMS * QUEUE_DEPTH;
	localparam int WA_W      = $clog2(WDEPTH);

	function automatic logic [Q_W-1:0] ring_next(input logic [Q_W-1:0] p);
		ring_next = (p == Q_W'(QUEUE_DEPTH - 1)) ? '0 : p + Q_W'(1);
	endfunction

	function automatic logic [WA_W-1:0] waddr(input logic [SLOT_W-1:0] s,
		input logic [Q_W-1:0] p);
		waddr = WA_W'(s) * WA_W'(QUEUE_DEPTH) + WA_W'(p);
	endfunction

	// captured item
	csb_pkg::cmd_e         cmd_q;
	logic [KEY_W-1:0]      key_q;
	logic [INIT_W-1:0]     init_q;
	logic [HANDLE_W-1:0]   handle_q;
	logic [TASKID_W-1:0]   task_q;

	logic [NUM_SEMS-1:0]   used_q;

	// storage
	logic [KEY_W-1:0]        key_mem  [NUM_SEMS];
	logic signed [CNT_W-1:0] cnt_mem  [NUM_SEMS];
	logic [Q_W-1:0]          head_mem [NUM_SEMS];
	logic [Q_W-1:0]          tail_mem [NUM_SEMS];
	logic [TASK_BITS-1:0]    wait_mem [WDEPTH];

	logic [KEY_W-1:0]        key_rd_s1;
	logic signed [CNT_W-1:0] cnt_rd_s1;
	logic [Q_W-1:0]          head_rd_s1;
	logic [Q_W-1:0]          tail_rd_s1;
	logic [TASK_BITS-1:0]    wait_rd_s1;

	// scan
	logic [IDX_W-1:0]  idx_q;
	logic              cmpv_s1;
	logic [SLOT_W-1:0] cmp_idx_s1;
	logic              hit_q;
	logic [SLOT_W-1:0] hit_idx_q;
	logic              free_found_q;
	logic [SLOT_W-1:0] free_idx_q;
	logic              idx_lt_n;

	// result and output registers
	csb_pkg::status_e       res_status_q;
	logic [SLOTOUT_W-1:0]   res_slot_q;
	logic                   res_wake_q;
	logic [TASKID_W-1:0]    res_woken_q;
	logic                   out_valid_q;
	csb_pkg::status_e       out_status_q;
	logic [SLOTOUT_W-1:0]   out_slot_q;
	logic                   out_wake_q;
	logic [TASKID_W-1:0]    out_woken_q;

	logic [SLOT_W-1:0]       h_idx;
	logic signed [CNT_W-1:0] cnt_dec;
	logic signed [CNT_W-1:0] cnt_inc;
	logic [Q_W-1:0]          head_nx;
	logic [Q_W-1:0]          tail_nx;
	logic                    q_full;
	logic                    q_empty;
	logic                    is_wait;
	logic                    is_open;
	logic                    would_block;
	logic                    sat;
	logic                    need_wake;
	logic                    do_enq;
	logic                    do_create;

	logic                    meta_we;
	logic [SLOT_W-1:0]       meta_wa;
	logic signed [CNT_W-1:0] cnt_wd;
	logic [Q_W-1:0]          head_wd;
	logic [Q_W-1:0]          tail_wd;

	assign h_idx       = SLOT_W'(handle_q);
	assign cnt_dec     = cnt_rd_s1 - CNT_W'(1);
	assign cnt_inc     = cnt_rd_s1 + CNT_W'(1);
	assign head_nx     = ring_next(head_rd_s1);
	assign tail_nx     = ring_next(tail_rd_s1);
	assign q_full      = (tail_nx == head_rd_s1);
	assign q_empty     = (head_rd_s1 == tail_rd_s1);
	assign is_wait     = (cmd_q == csb_pkg::CMD_WAIT);
	assign is_open     = (cmd_q == csb_pkg::CMD_OPEN);
	assign would_block = (cnt_dec < 0);
	assign sat         = (cnt_rd_s1 >= csb_pkg::COUNT_MAX);
	assign need_wake   = (cmd_q == csb_pkg::CMD_POST) && !sat && (cnt_inc <= 0) && !q_empty;
	assign do_enq      = cmd.upd && is_wait && would_block && !q_full;
	assign do_create   = cmd.scan_fin && is_open && !hit_q && free_found_q;
	assign idx_lt_n    = (idx_q < IDX_W'(NUM_SEMS));

	assign sts.is_scan   = (cmd_q == csb_pkg::CMD_OPEN) || (cmd_q == csb_pkg::CMD_UNLINK);
	assign sts.handle_ok = (32'(handle_q) < NUM_SEMS) && used_q[h_idx];
	assign sts.need_wake = need_wake;
	assign sts.scan_done = !idx_lt_n && !cmpv_s1;
	assign sts.out_free  = !out_valid_q || out_ready;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cmd_q    <= csb_pkg::cmd_e'(in_command);
			key_q    <= in_name_key;
			init_q   <= in_init_value;
			handle_q <= in_handle;
			task_q   <= in_task_id;
		end
	end

	// metadata write port: create on open, update on wait/post
	always_comb begin
		meta_we = 1'b0;
		meta_wa = h_idx;
		cnt_wd  = cnt_rd_s1;
		head_wd = head_rd_s1;
		tail_wd = tail_rd_s1;
		if (do_create) begin
			meta_we = 1'b1;
			meta_wa = free_idx_q;
			cnt_wd  = CNT_W'(init_q);
			head_wd = '0;
			tail_wd = '0;
		end else if (cmd.upd) begin
			if (is_wait) begin
				if (!would_block) begin
					meta_we = 1'b1;
					cnt_wd  = cnt_dec;
				end else if (!q_full) begin
					meta_we = 1'b1;
					cnt_wd  = cnt_dec;
					tail_wd = tail_nx;
				end
			end else if (!sat) begin
				meta_we = 1'b1;
				cnt_wd  = cnt_inc;
				if (need_wake) begin
					head_wd = head_nx;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (meta_we) begin
			cnt_mem[meta_wa]  <= cnt_wd;
			head_mem[meta_wa] <= head_wd;
			tail_mem[meta_wa] <= tail_wd;
		end
		cnt_rd_s1  <= cnt_mem[h_idx];
		head_rd_s1 <= head_mem[h_idx];
		tail_rd_s1 <= tail_mem[h_idx];
	end

	always_ff @(posedge clk) begin
		if (do_enq) begin
			wait_mem[waddr(h_idx, tail_rd_s1)] <= TASK_BITS'(task_q);
		end
		wait_rd_s1 <= wait_mem[waddr(h_idx, head_rd_s1)];
	end

	always_ff @(posedge clk) begin
		if (do_create) begin
			key_mem[free_idx_q] <= key_q;
		end
		if (cmd.scan && idx_lt_n) begin
			key_rd_s1 <= key_mem[idx_q[SLOT_W-1:0]];
		end
	end

	// key scan: read issued at idx_q, compared in the cycle after
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q        <= '0;
			cmpv_s1      <= 1'b0;
			cmp_idx_s1   <= '0;
			hit_q        <= 1'b0;
			hit_idx_q    <= '0;
			free_found_q <= 1'b0;
			free_idx_q   <= '0;
		end else if (cmd.scan_start) begin
			idx_q        <= '0;
			cmpv_s1      <= 1'b0;
			hit_q        <= 1'b0;
			free_found_q <= 1'b0;
		end else if (cmd.scan) begin
			if (idx_lt_n) begin
				idx_q <= idx_q + IDX_W'(1);
			end
			cmpv_s1    <= idx_lt_n;
			cmp_idx_s1 <= idx_q[SLOT_W-1:0];
			if (cmpv_s1) begin
				if (!hit_q && used_q[cmp_idx_s1] && key_rd_s1 == key_q) begin
					hit_q     <= 1'b1;
					hit_idx_q <= cmp_idx_s1;
				end
				if (!free_found_q && !used_q[cmp_idx_s1]) begin
					free_found_q <= 1'b1;
					free_idx_q   <= cmp_idx_s1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else if (cmd.scan_fin) begin
			if (do_create) begin
				used_q[free_idx_q] <= 1'b1;
			end else if (!is_open && hit_q) begin
				used_q[hit_idx_q] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_bad) begin
			res_status_q <= csb_pkg::ST_BAD_HANDLE;
			res_slot_q   <= '0;
			res_wake_q   <= 1'b0;
			res_woken_q  <= '0;
		end else if (cmd.upd) begin
			res_slot_q  <= '0;
			res_wake_q  <= 1'b0;
			res_woken_q <= '0;
			if (is_wait) begin
				if (!would_block) begin
					res_status_q <= csb_pkg::ST_OK;
				end else if (q_full) begin
					res_status_q <= csb_pkg::ST_QUEUE_FULL;
				end else begin
					res_status_q <= csb_pkg::ST_BLOCKED;
				end
			end else begin
				res_status_q <= sat ? csb_pkg::ST_SATURATED : csb_pkg::ST_OK;
			end
		end else if (cmd.wake_fin) begin
			res_status_q <= csb_pkg::ST_OK;
			res_slot_q   <= '0;
			res_wake_q   <= 1'b1;
			res_woken_q  <= TASKID_W'(wait_rd_s1);
		end else if (cmd.scan_fin) begin
			res_wake_q  <= 1'b0;
			res_woken_q <= '0;
			if (hit_q) begin
				res_status_q <= is_open ? csb_pkg::ST_FOUND : csb_pkg::ST_OK;
				res_slot_q   <= SLOTOUT_W'(hit_idx_q);
			end else if (!is_open) begin
				res_status_q <= csb_pkg::ST_NOT_FOUND;
				res_slot_q   <= '0;
			end else if (free_found_q) begin
				res_status_q <= csb_pkg::ST_OK;
				res_slot_q   <= SLOTOUT_W'(free_idx_q);
			end else begin
				res_status_q <= csb_pkg::ST_TABLE_FULL;
				res_slot_q   <= '0;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_status_q <= res_status_q;
			out_slot_q   <= res_slot_q;
			out_wake_q   <= res_wake_q;
			out_woken_q  <= res_woken_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_slot   = out_slot_q;
	assign out_wake   = out_wake_q;
	assign out_woken  = out_woken_q;

`ifndef SYNTHESIS
	a_wake_is_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_wake_q |-> out_status_q == csb_pkg::ST_OK)
		else $error("wake reported with non-ok status");

	a_woken_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_wake_q |-> out_woken_q == '0)
		else $error("woken task nonzero without wake");

	a_scan_drained: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_fin |-> !cmpv_s1 && !idx_lt_n)
		else $error("scan finished with compare pending");

	a_used_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.scan_fin |=> $stable(used_q))
		else $error("slot used bits changed outside open/unlink finish");

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.capture, cmd.upd, cmd.wake_fin, cmd.scan_fin, cmd.res_bad, cmd.emit}))
		else $error("conflicting datapath commands");
`endif

endmodule

/* tb/sv/counting_semaphore_bank_core_tb.sv */
`timescale 1ns / 1ps

module counting_semaphore_bank_core_tb;

	localparam int SEMS        = 16;
	localparam int POOL        = 12;
	localparam int STALL_LIMIT = 4000;
	localparam int ITEM_GOAL   = 1000;
	localparam int HOLD_AFTER  = 300;
	localparam int HOLD_CYCLES = 400;

	localparam int KEY_W     = csb_pkg::KEY_W;
	localparam int INIT_W    = csb_pkg::INIT_W;
	localparam int HANDLE_W  = csb_pkg::HANDLE_W;
	localparam int TASKID_W  = csb_pkg::TASKID_W;
	localparam int SLOTOUT_W = csb_pkg::SLOTOUT_W;

	localparam logic [KEY_W-1:0] KEY_ZERO = 64'h0000_0000_0000_0000;
	localparam logic [KEY_W-1:0] KEY_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [KEY_W-1:0] KEY_MSB  = 64'h8000_0000_0000_0001;
	localparam logic [KEY_W-1:0] KEY_ALT  = 64'h7FFF_FFFF_FFFF_FFFE;

	typedef struct packed {
		csb_pkg::cmd_e       command;
		logic [KEY_W-1:0]    name_key;
		logic [INIT_W-1:0]   init_value;
		logic [HANDLE_W-1:0] handle;
		logic [TASKID_W-1:0] task_id;
	} req_beat_t;

	typedef struct packed {
		csb_pkg::status_e     status;
		logic [SLOTOUT_W-1:0] slot_out;
		logic                 wake_valid;
		logic [TASKID_W-1:0]  woken_task;
	} sem_result_t;

	typedef struct {
		req_beat_t   beat;
		bit          pinned;
		sem_result_t want;
	} row_t;

	logic clk;
	logic arst_n;

	csb_req_if req();
	csb_rsp_if rsp();

	counting_semaphore_bank_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	// semaphore bank mirror
	bit                  sem_used [SEMS];
	logic [KEY_W-1:0]    sem_key [SEMS];
	int                  sem_count [SEMS];
	logic [TASKID_W-1:0] waiter_ring [SEMS][16];
	logic [3:0]          ring_head [SEMS];
	logic [3:0]          ring_tail [SEMS];

	sem_result_t      pending_results[$];
	int               mismatch_count;
	int               issued;
	int               beats_out;
	int               burst_left;
	int               gap_left;
	logic [KEY_W-1:0] key_pool [POOL];

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
	end

	function automatic int lookup_key(logic [KEY_W-1:0] k);
		for (int i = 0; i < SEMS; i++)
			if (sem_used[i] && sem_key[i] == k)
				return i;
		return -1;
	endfunction

	function automatic sem_result_t sem_bank_step(req_beat_t b);
		sem_result_t         r;
		int                  s;
		int                  c;
		logic [HANDLE_W-1:0] h;
		logic [3:0]          nxt;
		r = '0;
		r.status = csb_pkg::ST_OK;
		h = b.handle;
		case (b.command)
		csb_pkg::CMD_OPEN: begin
			s = lookup_key(b.name_key);
			if (s >= 0) begin
				r.status = csb_pkg::ST_FOUND;
				r.slot_out = SLOTOUT_W'(s);
			end else begin
				s = 0;
				while (s < SEMS && sem_used[s])
					s++;
				if (s == SEMS) begin
					r.status = csb_pkg::ST_TABLE_FULL;
				end else begin
					sem_used[s] = 1'b1;
					sem_key[s] = b.name_key;
					sem_count[s] = int'(b.init_value);
					ring_head[s] = '0;
					ring_tail[s] = '0;
					r.slot_out = SLOTOUT_W'(s);
				end
			end
		end
		csb_pkg::CMD_UNLINK: begin
			s = lookup_key(b.name_key);
			if (s < 0) begin
				r.status = csb_pkg::ST_NOT_FOUND;
			end else begin
				sem_used[s] = 1'b0;
				r.slot_out = SLOTOUT_W'(s);
			end
		end
		default: begin
			// 4-bit handle covers all 16 slots, so only the used bit can reject
			if (!sem_used[h]) begin
				r.status = csb_pkg::ST_BAD_HANDLE;
			end else if (b.command == csb_pkg::CMD_WAIT) begin
				c = sem_count[h] - 1;
				if (c < 0) begin
					// ring of 16 wraps on the 4-bit pointer; one entry stays empty
					nxt = ring_tail[h] + 4'd1;
					if (nxt == ring_head[h]) begin
						r.status = csb_pkg::ST_QUEUE_FULL;
					end else begin
						waiter_ring[h][ring_tail[h]] = b.task_id;
						ring_tail[h] = nxt;
						sem_count[h] = c;
						r.status = csb_pkg::ST_BLOCKED;
					end
				end else begin
					sem_count[h] = c;
				end
			end else begin
				if (sem_count[h] >= int'(csb_pkg::COUNT_MAX)) begin
					r.status = csb_pkg::ST_SATURATED;
				end else begin
					c = sem_count[h] + 1;
					sem_count[h] = c;
					if (c <= 0 && ring_head[h] != ring_tail[h]) begin
						r.wake_valid = 1'b1;
						r.woken_task = waiter_ring[h][ring_head[h]];
						ring_head[h] = ring_head[h] + 4'd1;
					end
				end
			end
		end
		endcase
		return r;
	endfunction

	function automatic req_beat_t make_beat(csb_pkg::cmd_e c, logic [KEY_W-1:0] k, int init,
			int h, int t);
		req_beat_t b;
		b.command = c;
		b.name_key = k;
		b.init_value = INIT_W'(init);
		b.handle = HANDLE_W'(h);
		b.task_id = TASKID_W'(t);
		return b;
	endfunction

	function automatic row_t plan_row(csb_pkg::cmd_e c, logic [KEY_W-1:0] k, int init, int h,
			int t, bit pin, csb_pkg::status_e s = csb_pkg::ST_OK, int so = 0,
			bit wv = 1'b0, int wt = 0);
		row_t r;
		r.beat = make_beat(c, k, init, h, t);
		r.pinned = pin;
		r.want.status = s;
		r.want.slot_out = SLOTOUT_W'(so);
		r.want.wake_valid = wv;
		r.want.woken_task = TASKID_W'(wt);
		return r;
	endfunction

	function automatic logic [KEY_W-1:0] rand_key();
		return {$urandom, $urandom};
	endfunction

	function automatic int pick_init();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return $urandom_range(0, 2);
		if (r < 70)
			return $urandom_range(3, 40);
		if (r < 80)
			return $urandom_range(32760, 32767);
		return $urandom_range(0, 32767);
	endfunction

	task automatic report_mismatch(string msg);
		mismatch_count++;
		if (mismatch_count <= 40)
			$display("MISMATCH at %0t: %s", $time, msg);
	endtask

	// entered at a clock edge; returns at the edge where the beat is taken
	task automatic send_beat(req_beat_t b, bit pinned, sem_result_t pin_res);
		sem_result_t got;
		while (gap_left > 0) begin
			req.valid <= 1'b0;
			gap_left--;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.command <= b.command;
		req.name_key <= b.name_key;
		req.init_value <= b.init_value;
		req.handle <= b.handle;
		req.task_id <= b.task_id;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		got = sem_bank_step(b);
		pending_results.push_back(pinned ? pin_res : got);
		issued++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 40);
			gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
		end
	endtask

	task automatic offer(csb_pkg::cmd_e c, logic [KEY_W-1:0] k, int init, int h, int t);
		send_beat(make_beat(c, k, init, h, t), 1'b0, '0);
	endtask

	task automatic touch(bit is_wait, int h);
		if (is_wait)
			offer(csb_pkg::CMD_WAIT, rand_key(), $urandom_range(0, 32767), h,
				$urandom_range(0, 255));
		else
			offer(csb_pkg::CMD_POST, rand_key(), $urandom_range(0, 32767), h,
				$urandom_range(0, 255));
	endtask

	task automatic open_key(logic [KEY_W-1:0] k, int init, output int h);
		offer(csb_pkg::CMD_OPEN, k, init, $urandom_range(0, SEMS-1), $urandom_range(0, 255));
		h = lookup_key(k);
		if (h < 0)
			h = $urandom_range(0, SEMS-1);
	endtask

	task automatic run_episode();
		logic [KEY_W-1:0] k;
		int               h;
		int               n;
		int               pick;
		int               r;
		int               used_list[$];
		pick = $urandom_range(0, 99);
		if (pick < 30) begin
			// ordinary traffic on one semaphore
			open_key(key_pool[$urandom_range(0, POOL-1)], pick_init(), h);
			n = $urandom_range(4, 24);
			repeat (n) begin
				if ($urandom_range(0, 19) == 0)
					touch(1'($urandom_range(0, 1)), $urandom_range(0, SEMS-1));
				else
					touch($urandom_range(0, 99) < 55, h);
			end
		end else if (pick < 42) begin
			// pile up waiters, at times past the ring size, then drain them
			open_key(key_pool[$urandom_range(0, POOL-1)], $urandom_range(0, 1), h);
			repeat ($urandom_range(14, 18))
				touch(1'b1, h);
			repeat ($urandom_range(14, 18))
				touch(1'b0, h);
		end else if (pick < 50) begin
			// walk the count into saturation
			open_key(rand_key(), $urandom_range(32764, 32767), h);
			repeat ($urandom_range(2, 5))
				touch(1'b0, h);
			touch(1'b1, h);
			repeat ($urandom_range(1, 2))
				touch(1'b0, h);
		end else if (pick < 58) begin
			// fill every free slot and one more
			n = 1;
			for (int i = 0; i < SEMS; i++)
				if (!sem_used[i])
					n++;
			repeat (n)
				offer(csb_pkg::CMD_OPEN, rand_key(), pick_init(), $urandom_range(0, SEMS-1),
					$urandom_range(0, 255));
		end else if (pick < 78) begin
			repeat ($urandom_range(1, 4)) begin
				used_list.delete();
				for (int i = 0; i < SEMS; i++)
					if (sem_used[i])
						used_list.push_back(i);
				r = $urandom_range(0, 99);
				if (r < 70 && used_list.size() > 0)
					k = sem_key[used_list[$urandom_range(0, used_list.size()-1)]];
				else if (r < 85)
					k = key_pool[$urandom_range(0, POOL-1)];
				else
					k = rand_key();
				offer(csb_pkg::CMD_UNLINK, k, $urandom_range(0, 32767),
					$urandom_range(0, SEMS-1), $urandom_range(0, 255));
			end
		end else if (pick < 90) begin
			repeat ($urandom_range(1, 6)) begin
				k = ($urandom_range(0, 1) == 1) ? rand_key() : key_pool[$urandom_range(0, POOL-1)];
				offer(csb_pkg::cmd_e'($urandom_range(0, 3)), k, $urandom_range(0, 32767),
					$urandom_range(0, SEMS-1), $urandom_range(0, 255));
			end
		end else begin
			// reopen a live name, then use it
			for (int i = 0; i < SEMS; i++)
				if (sem_used[i])
					used_list.push_back(i);
			if (used_list.size() > 0)
				k = sem_key[used_list[$urandom_range(0, used_list.size()-1)]];
			else
				k = key_pool[$urandom_range(0, POOL-1)];
			open_key(k, pick_init(), h);
			repeat ($urandom_range(2, 8))
				touch(1'($urandom_range(0, 1)), h);
		end
	endtask

	always @(posedge clk) begin : check_results
		sem_result_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			beats_out++;
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("beat %0d with nothing pending, status %0d",
					beats_out, rsp.status));
			end else begin
				want = pending_results.pop_front();
				if (rsp.status !== want.status)
					report_mismatch($sformatf("beat %0d status %0d, want %0d",
						beats_out, rsp.status, want.status));
				if (rsp.slot_out !== want.slot_out)
					report_mismatch($sformatf("beat %0d slot_out %0d, want %0d",
						beats_out, rsp.slot_out, want.slot_out));
				if (rsp.wake_valid !== want.wake_valid)
					report_mismatch($sformatf("beat %0d wake_valid %0b, want %0b",
						beats_out, rsp.wake_valid, want.wake_valid));
				if (rsp.woken_task !== want.woken_task)
					report_mismatch($sformatf("beat %0d woken_task %0d, want %0d",
						beats_out, rsp.woken_task, want.woken_task));
			end
		end
	end

	initial begin : rsp_side
		int  mode;
		int  mode_left;
		int  stall_left;
		int  tick;
		bit  held;
		mode = 0;
		mode_left = 0;
		stall_left = 0;
		tick = 0;
		held = 1'b0;
		rsp.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			tick++;
			if (!held && beats_out >= HOLD_AFTER) begin
				// long back-pressure: output register fills, request side backs up
				held = 1'b1;
				rsp.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				if (mode_left == 0) begin
					mode = $urandom_range(0, 3);
					mode_left = $urandom_range(20, 150);
				end
				mode_left--;
				case (mode)
				0: rsp.ready <= 1'b1;
				1: rsp.ready <= 1'($urandom_range(0, 1));
				2: rsp.ready <= (tick % 5) != 0;
				default: begin
					if (stall_left > 0) begin
						stall_left--;
						rsp.ready <= 1'b0;
					end else begin
						rsp.ready <= 1'b1;
						if ($urandom_range(0, 7) == 0)
							stall_left = $urandom_range(1, 20);
					end
				end
				endcase
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin : stimulus
		row_t plan[$];
		req.valid <= 1'b0;
		req.command <= csb_pkg::CMD_OPEN;
		req.name_key <= '0;
		req.init_value <= '0;
		req.handle <= '0;
		req.task_id <= '0;
		mismatch_count = 0;
		issued = 0;
		beats_out = 0;
		burst_left = 0;
		gap_left = 0;
		for (int i = 0; i < POOL; i++)
			key_pool[i] = rand_key();
		key_pool[0] = KEY_ZERO;
		key_pool[1] = KEY_ONES;

		plan.push_back(plan_row(csb_pkg::CMD_WAIT,   KEY_ZERO, 0,     0,  0,     1,
			csb_pkg::ST_BAD_HANDLE));
		plan.push_back(plan_row(csb_pkg::CMD_POST,   KEY_ZERO, 0,     15, 0,     1,
			csb_pkg::ST_BAD_HANDLE));
		plan.push_back(plan_row(csb_pkg::CMD_UNLINK, KEY_ZERO, 0,     0,  0,     1,
			csb_pkg::ST_NOT_FOUND));
		plan.push_back(plan_row(csb_pkg::CMD_OPEN,   KEY_ONES, 32767, 0,  0,     1,
			csb_pkg::ST_OK, 0));
		plan.push_back(plan_row(csb_pkg::CMD_OPEN,   KEY_ZERO, 0,     0,  0,     1,
			csb_pkg::ST_OK, 1));
		plan.push_back(plan_row(csb_pkg::CMD_OPEN,   KEY_ONES, 5,     0,  0,     1,
			csb_pkg::ST_FOUND, 0));
		plan.push_back(plan_row(csb_pkg::CMD_POST,   KEY_ZERO, 0,     0,  0,     1,
			csb_pkg::ST_SATURATED));
		plan.push_back(plan_row(csb_pkg::CMD_WAIT,   KEY_ZERO, 0,     0,  8'hA5, 0));
		plan.push_back(plan_row(csb_pkg::CMD_POST,   KEY_ZERO, 0,     0,  0,     0));
		plan.push_back(plan_row(csb_pkg::CMD_WAIT,   KEY_ZERO, 0,     1,  8'hFF, 1,
			csb_pkg::ST_BLOCKED));
		plan.push_back(plan_row(csb_pkg::CMD_WAIT,   KEY_ZERO, 0,     1,  8'h00, 0));
		plan.push_back(plan_row(csb_pkg::CMD_POST,   KEY_ZERO, 0,     1,  0,     1,
			csb_pkg::ST_OK, 0, 1, 8'hFF));
		plan.push_back(plan_row(csb_pkg::CMD_POST,   KEY_ZERO, 0,     1,  0,     0));
		plan.push_back(plan_row(csb_pkg::CMD_POST,   KEY_ZERO, 0,     1,  0,     0));
		plan.push_back(plan_row(csb_pkg::CMD_WAIT,   KEY_ZERO, 0,     15, 8'hFF, 1,
			csb_pkg::ST_BAD_HANDLE));
		plan.push_back(plan_row(csb_pkg::CMD_OPEN,   KEY_MSB,  1,     0,  0,     1,
			csb_pkg::ST_OK, 2));
		plan.push_back(plan_row(csb_pkg::CMD_UNLINK, KEY_ZERO, 0,     0,  0,     1,
			csb_pkg::ST_OK, 1));
		plan.push_back(plan_row(csb_pkg::CMD_WAIT,   KEY_ZERO, 0,     1,  0,     1,
			csb_pkg::ST_BAD_HANDLE));
		plan.push_back(plan_row(csb_pkg::CMD_OPEN,   KEY_ALT,  16384, 0,  0,     1,
			csb_pkg::ST_OK, 1));
		plan.push_back(plan_row(csb_pkg::CMD_WAIT,   KEY_ZERO, 0,     2,  8'h5A, 0));
		plan.push_back(plan_row(csb_pkg::CMD_WAIT,   KEY_ZERO, 0,     2,  8'h3C, 0));
		// unlink drops the queued waiter; reopen must start with an empty ring
		plan.push_back(plan_row(csb_pkg::CMD_UNLINK, KEY_MSB,  0,     0,  0,     1,
			csb_pkg::ST_OK, 2));
		plan.push_back(plan_row(csb_pkg::CMD_OPEN,   KEY_MSB,  0,     0,  0,     1,
			csb_pkg::ST_OK, 2));
		plan.push_back(plan_row(csb_pkg::CMD_POST,   KEY_ZERO, 0,     2,  0,     0));
		plan.push_back(plan_row(csb_pkg::CMD_UNLINK, KEY_ONES, 0,     0,  0,     1,
			csb_pkg::ST_OK, 0));

		wait (arst_n === 1'b1);
		@(posedge clk);
		foreach (plan[i])
			send_beat(plan[i].beat, plan[i].pinned, plan[i].want);
		while (issued < ITEM_GOAL)
			run_episode();
		req.valid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatch_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
